FILE: rtl/iolp_pkg.sv
package iolp_pkg;

   // table and label sizing
   localparam int MAX_ENTRIES = 256;
   localparam int NUM_LABELS  = 16;
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int LBL_W       = $clog2(NUM_LABELS);

   // field widths
   localparam int TIME_W  = 32;
   localparam int LABEL_W = 4;
   localparam int SUM_W   = 40;

   // operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // one stored interval
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [TIME_W-1:0]  duration;
      logic [TIME_W-1:0]  start;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: rtl/iolp_ram.sv
module iolp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/interval_overlap_label_picker.sv
// clear and load words leave the block idle; the next word is taken at the following edge
// a query word walks the stored intervals and then scans the per speaker sums, and it
// walks the memory a second time when nothing overlaps, before it raises rsp_valid
// an empty table goes straight to raising rsp_valid; after a query req_ready returns in the
// cycle that rsp_valid rises, later while an older result is still stalled
// synchronous reset empties the table, clears overflow and drops any pending result
module interval_overlap_label_picker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_operation,
   input  logic [iolp_pkg::TIME_W-1:0]        req_time_start,
   input  logic [iolp_pkg::TIME_W-1:0]        req_time_span,
   input  logic [iolp_pkg::LABEL_W-1:0]       req_label_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [iolp_pkg::LABEL_W-1:0]       rsp_label_out,
   output logic                               rsp_label_unknown,
   output logic                               rsp_by_nearest,
   output logic [iolp_pkg::TIME_W-1:0]        rsp_query_start,
   output logic [iolp_pkg::TIME_W-1:0]        rsp_query_duration,
   output logic                               rsp_table_overflow
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_WALK_OV   = 5'b00010,
      ST_SCAN      = 5'b00100,
      ST_WALK_NEAR = 5'b01000,
      ST_DONE      = 5'b10000
   } state_type;

   localparam int TW = iolp_pkg::TIME_W;
   localparam int SW = iolp_pkg::SUM_W;

   // control registers
   state_type                     state_ff, state_in;
   logic [iolp_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          overflow_ff, overflow_in;
   logic                          issue_ff, issue_in;
   logic [iolp_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic                          v0_ff, v0_in;
   logic                          v1_ff, v1_in;
   logic                          v2_ff, v2_in;
   logic                          first_ff, first_in;
   logic [iolp_pkg::LBL_W-1:0]    scan_ff, scan_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // query context
   logic [TW-1:0]                 qs_ff, qs_in;
   logic [TW-1:0]                 qe_ff, qe_in;
   logic [TW+1:0]                 qmid_ff, qmid_in;
   logic [TW-1:0]                 qdur_ff, qdur_in;
   logic                          unknown_ff, unknown_in;
   logic                          nearest_ff, nearest_in;

   // pipeline stage one
   logic [TW-1:0]                 s1_lo_ff, s1_lo_in;
   logic [TW:0]                   s1_end_ff, s1_end_in;
   logic [TW+1:0]                 s1_mid_ff, s1_mid_in;
   logic [iolp_pkg::LABEL_W-1:0]  s1_label_ff, s1_label_in;
   logic [TW-1:0]                 s1_start_ff, s1_start_in;

   // pipeline stage two
   logic [TW:0]                   s2_ov_ff, s2_ov_in;
   logic [TW+1:0]                 s2_gap_ff, s2_gap_in;
   logic [iolp_pkg::LABEL_W-1:0]  s2_label_ff, s2_label_in;
   logic [TW-1:0]                 s2_start_ff, s2_start_in;

   // per speaker sums and best candidate
   logic [SW-1:0]                 sum_ff [0:iolp_pkg::NUM_LABELS-1];
   logic [SW-1:0]                 sum_in [0:iolp_pkg::NUM_LABELS-1];
   logic [SW-1:0]                 best_sum_ff, best_sum_in;
   logic [iolp_pkg::LABEL_W-1:0]  best_label_ff, best_label_in;
   logic [TW+1:0]                 best_gap_ff, best_gap_in;
   logic [TW-1:0]                 best_start_ff, best_start_in;

   // output registers
   logic [iolp_pkg::LABEL_W-1:0]  rsp_label_ff, rsp_label_in;
   logic                          rsp_unknown_ff, rsp_unknown_in;
   logic                          rsp_nearest_ff, rsp_nearest_in;
   logic [TW-1:0]                 rsp_start_ff, rsp_start_in;
   logic [TW-1:0]                 rsp_dur_ff, rsp_dur_in;
   logic                          rsp_overflow_ff, rsp_overflow_in;

   // memory port signals
   logic                          wr_en;
   logic [iolp_pkg::ADDR_W-1:0]   wr_addr;
   iolp_pkg::entry_type           wr_entry;
   logic                          rd_en;
   logic [iolp_pkg::ADDR_W-1:0]   rd_addr;
   logic [iolp_pkg::ENTRY_W-1:0]  rd_word;
   iolp_pkg::entry_type           rd_entry;

   // helpers
   logic                          accept;
   logic                          drained;
   logic [iolp_pkg::LABEL_W-1:0]  load_label;
   logic [TW:0]                   hi;
   logic [SW:0]                   sum_total;
   logic [iolp_pkg::LBL_W-1:0]    acc_idx;
   logic [SW-1:0]                 scan_sum;
   logic                          scan_take;
   logic                          near_take;

   iolp_ram #(
      .WIDTH (iolp_pkg::ENTRY_W),
      .DEPTH (iolp_pkg::MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry  = iolp_pkg::entry_type'(rd_word);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign drained   = !issue_ff && !v0_ff && !v1_ff && !v2_ff;

   // labels past the last speaker fold onto it
   assign load_label = (req_label_in > iolp_pkg::LABEL_W'(iolp_pkg::NUM_LABELS - 1))
                     ? iolp_pkg::LABEL_W'(iolp_pkg::NUM_LABELS - 1) : req_label_in;

   // load path into the interval memory
   assign wr_en          = accept && (req_operation == iolp_pkg::OP_LOAD)
                        && (count_ff < iolp_pkg::CNT_W'(iolp_pkg::MAX_ENTRIES));
   assign wr_addr        = count_ff[iolp_pkg::ADDR_W-1:0];
   assign wr_entry.start    = req_time_start;
   assign wr_entry.duration = req_time_span;
   assign wr_entry.label    = load_label;

   // walk read port
   assign rd_en   = issue_ff;
   assign rd_addr = idx_ff[iolp_pkg::ADDR_W-1:0];

   // stage two overlap and distance
   assign hi = (s1_end_ff < {1'b0, qe_ff}) ? s1_end_ff : {1'b0, qe_ff};

   // stage three accumulate and compare
   assign acc_idx   = iolp_pkg::LBL_W'(s2_label_ff);
   assign sum_total = {1'b0, sum_ff[acc_idx]} + (SW + 1)'(s2_ov_ff);
   assign scan_sum  = sum_ff[scan_ff];
   assign scan_take = scan_sum > best_sum_ff;
   assign near_take = first_ff
                   || (s2_gap_ff < best_gap_ff)
                   || ((s2_gap_ff == best_gap_ff) && (s2_label_ff < best_label_ff))
                   || ((s2_gap_ff == best_gap_ff) && (s2_label_ff == best_label_ff)
                       && (s2_start_ff < best_start_ff));

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      overflow_in     = overflow_ff;
      issue_in        = issue_ff;
      idx_in          = idx_ff;
      v0_in           = issue_ff;
      v1_in           = v0_ff;
      v2_in           = v1_ff;
      first_in        = first_ff;
      scan_in         = scan_ff;
      rsp_valid_in    = rsp_valid_ff;
      qs_in           = qs_ff;
      qe_in           = qe_ff;
      qmid_in         = qmid_ff;
      qdur_in         = qdur_ff;
      unknown_in      = unknown_ff;
      nearest_in      = nearest_ff;
      sum_in          = sum_ff;
      best_sum_in     = best_sum_ff;
      best_label_in   = best_label_ff;
      best_gap_in     = best_gap_ff;
      best_start_in   = best_start_ff;
      rsp_label_in    = rsp_label_ff;
      rsp_unknown_in  = rsp_unknown_ff;
      rsp_nearest_in  = rsp_nearest_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_dur_in      = rsp_dur_ff;
      rsp_overflow_in = rsp_overflow_ff;

      // stage one: stored end, clipped start and doubled midpoint
      s1_lo_in    = (rd_entry.start > qs_ff) ? rd_entry.start : qs_ff;
      s1_end_in   = {1'b0, rd_entry.start} + {1'b0, rd_entry.duration};
      s1_mid_in   = {1'b0, rd_entry.start, 1'b0} + {2'b00, rd_entry.duration};
      s1_label_in = rd_entry.label;
      s1_start_in = rd_entry.start;

      // stage two: positive overlap and midpoint distance
      s2_ov_in    = (hi > {1'b0, s1_lo_ff}) ? (hi - {1'b0, s1_lo_ff}) : '0;
      s2_gap_in   = (s1_mid_ff > qmid_ff) ? (s1_mid_ff - qmid_ff) : (qmid_ff - s1_mid_ff);
      s2_label_in = s1_label_ff;
      s2_start_in = s1_start_ff;

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // address walk, one entry per cycle
      if (issue_ff) begin
         if (idx_ff == count_ff - iolp_pkg::CNT_W'(1)) begin
            issue_in = 1'b0;
         end else begin
            idx_in = idx_ff + iolp_pkg::CNT_W'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  iolp_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  iolp_pkg::OP_LOAD: begin
                     if (wr_en) begin
                        count_in = count_ff + iolp_pkg::CNT_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  iolp_pkg::OP_QUERY: begin
                     qs_in         = req_time_start;
                     qe_in         = req_time_span;
                     qmid_in       = {1'b0, ({1'b0, req_time_start} + {1'b0, req_time_span})};
                     qdur_in       = (req_time_span > req_time_start)
                                   ? (req_time_span - req_time_start) : '0;
                     nearest_in    = 1'b0;
                     best_label_in = '0;
                     best_sum_in   = '0;
                     for (int i = 0; i < iolp_pkg::NUM_LABELS; i++) begin
                        sum_in[i] = '0;
                     end
                     if (count_ff == '0) begin
                        unknown_in = 1'b1;
                        state_in   = ST_DONE;
                     end else begin
                        unknown_in = 1'b0;
                        issue_in   = 1'b1;
                        idx_in     = '0;
                        state_in   = ST_WALK_OV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK_OV: begin
            if (v2_ff) begin
               sum_in[acc_idx] = sum_total[SW] ? {SW{1'b1}} : sum_total[SW-1:0];
            end
            if (drained) begin
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_take) begin
               best_sum_in   = scan_sum;
               best_label_in = iolp_pkg::LABEL_W'(scan_ff);
            end
            if (scan_ff == iolp_pkg::LBL_W'(iolp_pkg::NUM_LABELS - 1)) begin
               if (scan_take || (best_sum_ff != '0)) begin
                  state_in = ST_DONE;
               end else begin
                  issue_in   = 1'b1;
                  idx_in     = '0;
                  first_in   = 1'b1;
                  nearest_in = 1'b1;
                  state_in   = ST_WALK_NEAR;
               end
            end else begin
               scan_in = scan_ff + iolp_pkg::LBL_W'(1);
            end
         end
         ST_WALK_NEAR: begin
            if (v2_ff) begin
               first_in = 1'b0;
               if (near_take) begin
                  best_gap_in   = s2_gap_ff;
                  best_label_in = s2_label_ff;
                  best_start_in = s2_start_ff;
               end
            end
            if (drained) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_label_in    = best_label_ff;
               rsp_unknown_in  = unknown_ff;
               rsp_nearest_in  = nearest_ff;
               rsp_start_in    = qs_ff;
               rsp_dur_in      = qdur_ff;
               rsp_overflow_in = overflow_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         issue_ff     <= 1'b0;
         idx_ff       <= '0;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         first_ff     <= 1'b0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         issue_ff     <= issue_in;
         idx_ff       <= idx_in;
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         first_ff     <= first_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      qs_ff           <= qs_in;
      qe_ff           <= qe_in;
      qmid_ff         <= qmid_in;
      qdur_ff         <= qdur_in;
      unknown_ff      <= unknown_in;
      nearest_ff      <= nearest_in;
      s1_lo_ff        <= s1_lo_in;
      s1_end_ff       <= s1_end_in;
      s1_mid_ff       <= s1_mid_in;
      s1_label_ff     <= s1_label_in;
      s1_start_ff     <= s1_start_in;
      s2_ov_ff        <= s2_ov_in;
      s2_gap_ff       <= s2_gap_in;
      s2_label_ff     <= s2_label_in;
      s2_start_ff     <= s2_start_in;
      sum_ff          <= sum_in;
      best_sum_ff     <= best_sum_in;
      best_label_ff   <= best_label_in;
      best_gap_ff     <= best_gap_in;
      best_start_ff   <= best_start_in;
      rsp_label_ff    <= rsp_label_in;
      rsp_unknown_ff  <= rsp_unknown_in;
      rsp_nearest_ff  <= rsp_nearest_in;
      rsp_start_ff    <= rsp_start_in;
      rsp_dur_ff      <= rsp_dur_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   // result ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_label_out      = rsp_label_ff;
   assign rsp_label_unknown  = rsp_unknown_ff;
   assign rsp_by_nearest     = rsp_nearest_ff;
   assign rsp_query_start    = rsp_start_ff;
   assign rsp_query_duration = rsp_dur_ff;
   assign rsp_table_overflow = rsp_overflow_ff;

endmodule

FILE: rtl/iolp_checker.sv
module iolp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [1:0]                         req_operation,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [iolp_pkg::LABEL_W-1:0]       rsp_label_out,
   input logic                               rsp_label_unknown,
   input logic                               rsp_by_nearest,
   input logic [iolp_pkg::TIME_W-1:0]        rsp_query_start,
   input logic [iolp_pkg::TIME_W-1:0]        rsp_query_duration,
   input logic                               rsp_table_overflow
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_label_out)
         && $stable(rsp_label_unknown) && $stable(rsp_by_nearest)
         && $stable(rsp_query_start) && $stable(rsp_query_duration)
         && $stable(rsp_table_overflow))
      else $error("result word changed while stalled");

   // an empty-table answer carries no label and no nearest flag
   a_unknown_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_label_unknown |-> !rsp_by_nearest && (rsp_label_out == '0))
      else $error("unknown result with label or nearest flag");

   // the block is busy in the cycle after a query word is accepted
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == iolp_pkg::OP_QUERY) |=> !req_ready)
      else $error("query accepted back to back");

   // reset leaves the block ready with no pending result
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind interval_overlap_label_picker iolp_checker u_iolp_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // package sizes and codes used here
   localparam int MAX_ENTRIES = iolp_pkg::MAX_ENTRIES;
   localparam int NUM_LABELS  = iolp_pkg::NUM_LABELS;
   localparam int TIME_W      = iolp_pkg::TIME_W;
   localparam int LABEL_W     = iolp_pkg::LABEL_W;
   localparam int SUM_W       = iolp_pkg::SUM_W;
   localparam logic [1:0] OP_CLEAR = iolp_pkg::OP_CLEAR;
   localparam logic [1:0] OP_LOAD  = iolp_pkg::OP_LOAD;
   localparam logic [1:0] OP_QUERY = iolp_pkg::OP_QUERY;

   // unused operation code, the block drops such words
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // a full-table query with no overlap walks the table twice
   localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES + NUM_LABELS + 32;
   localparam int LIMIT_CYCLES  = 5_000_000;
   localparam int PHASE_WORDS   = 220;

   localparam logic [SUM_W:0] SUM_MAX = {1'b0, {SUM_W{1'b1}}};

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               unknown;
      logic               nearest;
      logic [TIME_W-1:0]  start;
      logic [TIME_W-1:0]  duration;
      logic               overflow;
   } label_pick_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_operation = OP_CLEAR;
   logic [TIME_W-1:0]   req_time_start = '0;
   logic [TIME_W-1:0]   req_time_span = '0;
   logic [LABEL_W-1:0]  req_label_in = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [LABEL_W-1:0]  rsp_label_out;
   logic                rsp_label_unknown;
   logic                rsp_by_nearest;
   logic [TIME_W-1:0]   rsp_query_start;
   logic [TIME_W-1:0]   rsp_query_duration;
   logic                rsp_table_overflow;

   // shadow copy of the interval table
   logic [TIME_W-1:0]   tbl_start [MAX_ENTRIES];
   logic [TIME_W-1:0]   tbl_dur   [MAX_ENTRIES];
   logic [LABEL_W-1:0]  tbl_label [MAX_ENTRIES];
   int                  tbl_count = 0;
   logic                tbl_overflow = 1'b0;

   label_pick_type      pending_picks [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int n_errors = 0;
   int n_words = 0;
   int n_results = 0;
   int n_nearest = 0;
   int n_unknown = 0;

   interval_overlap_label_picker DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_time_start     (req_time_start),
      .req_time_span      (req_time_span),
      .req_label_in       (req_label_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_label_out      (rsp_label_out),
      .rsp_label_unknown  (rsp_label_unknown),
      .rsp_by_nearest     (rsp_by_nearest),
      .rsp_query_start    (rsp_query_start),
      .rsp_query_duration (rsp_query_duration),
      .rsp_table_overflow (rsp_table_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d answers still pending",
                  cycle_count, pending_picks.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // speaker pick for one query against the shadow table
   function automatic label_pick_type pick_label_for(logic [TIME_W-1:0] qs,
                                                     logic [TIME_W-1:0] qe);
      label_pick_type     pick;
      logic [SUM_W-1:0]   sums [NUM_LABELS];
      logic [SUM_W:0]     acc;
      logic [SUM_W-1:0]   best_sum;
      logic [TIME_W:0]    lo, hi, e_end;
      logic [TIME_W+1:0]  q_mid2, e_mid2, gap, near_gap;
      logic [TIME_W-1:0]  best_start;
      logic [LABEL_W-1:0] best_lbl;
      logic [LABEL_W-1:0] lbl;
      bit                 any_overlap;
      bit                 take;
      pick = '0;
      pick.start = qs;
      pick.duration = (qe > qs) ? qe - qs : '0;
      pick.overflow = tbl_overflow;
      best_lbl = '0;
      if (tbl_count == 0) begin
         pick.unknown = 1'b1;
      end else begin
         for (int l = 0; l < NUM_LABELS; l++) sums[l] = '0;
         // overlap per speaker, saturating
         for (int i = 0; i < tbl_count; i++) begin
            e_end = {1'b0, tbl_start[i]} + {1'b0, tbl_dur[i]};
            lo = (tbl_start[i] > qs) ? {1'b0, tbl_start[i]} : {1'b0, qs};
            hi = (e_end < {1'b0, qe}) ? e_end : {1'b0, qe};
            if (hi > lo) begin
               acc = {1'b0, sums[tbl_label[i]]} + (hi - lo);
               sums[tbl_label[i]] = (acc > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : acc[SUM_W-1:0];
            end
         end
         // largest sum, lowest speaker on a tie
         best_sum = '0;
         any_overlap = 1'b0;
         for (int l = 0; l < NUM_LABELS; l++) begin
            if (sums[l] > best_sum) begin
               best_sum = sums[l];
               best_lbl = LABEL_W'(l);
               any_overlap = 1'b1;
            end
         end
         // nearest doubled midpoint when nothing overlaps
         if (!any_overlap) begin
            q_mid2 = {2'b00, qs} + {2'b00, qe};
            near_gap = '0;
            best_start = '0;
            for (int i = 0; i < tbl_count; i++) begin
               e_mid2 = {1'b0, tbl_start[i], 1'b0} + {2'b00, tbl_dur[i]};
               gap = (e_mid2 > q_mid2) ? e_mid2 - q_mid2 : q_mid2 - e_mid2;
               lbl = tbl_label[i];
               if (i == 0) take = 1'b1;
               else if (gap != near_gap) take = gap < near_gap;
               else if (lbl != best_lbl) take = lbl < best_lbl;
               else take = tbl_start[i] < best_start;
               if (take) begin
                  near_gap = gap;
                  best_lbl = lbl;
                  best_start = tbl_start[i];
               end
            end
         end
         pick.nearest = !any_overlap;
      end
      pick.label = best_lbl;
      return pick;
   endfunction

   // update the shadow table for one accepted word
   task automatic apply_word(logic [1:0] op, logic [TIME_W-1:0] ts,
                             logic [TIME_W-1:0] tspan, logic [LABEL_W-1:0] lbl);
      case (op)
         OP_CLEAR: tbl_count = 0;
         OP_LOAD: begin
            if (tbl_count < MAX_ENTRIES) begin
               tbl_start[tbl_count] = ts;
               tbl_dur[tbl_count] = tspan;
               tbl_label[tbl_count] = (lbl >= NUM_LABELS) ? LABEL_W'(NUM_LABELS - 1) : lbl;
               tbl_count++;
            end else begin
               tbl_overflow = 1'b1;
            end
         end
         OP_QUERY: pending_picks.insert(pending_picks.size(), pick_label_for(ts, tspan));
         default: ;
      endcase
   endtask

   // drive one word and hold it until accepted
   task automatic send_word(logic [1:0] op, logic [TIME_W-1:0] ts,
                            logic [TIME_W-1:0] tspan, logic [LABEL_W-1:0] lbl);
      bit took;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_time_start <= ts;
      req_time_span <= tspan;
      req_label_in <= lbl;
      do begin
         @(negedge clock);
         took = (req_ready === 1'b1);
         @(posedge clock);
      end while (!took);
      apply_word(op, ts, tspan, lbl);
      if (op != OP_UNUSED) n_words++;
   endtask

   // hold off the sender until every pending answer is back
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_picks.size() != 0);
   endtask

   task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (got !== want) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // compare each accepted answer with the oldest pending pick
   always @(negedge clock) begin : check_answers
      label_pick_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_picks.size() == 0) begin
            n_errors++;
            $display("%0t: answer with no query pending, expected none, got label %0h",
                     $time, rsp_label_out);
         end else begin
            want = pending_picks.pop_front();
            n_results++;
            if (want.nearest) n_nearest++;
            if (want.unknown) n_unknown++;
            check_field("label_out", want.label, rsp_label_out);
            check_field("label_unknown", want.unknown, rsp_label_unknown);
            check_field("by_nearest", want.nearest, rsp_by_nearest);
            check_field("query_start", want.start, rsp_query_start);
            check_field("query_duration", want.duration, rsp_query_duration);
            check_field("table_overflow", want.overflow, rsp_table_overflow);
         end
      end
   end

   // hand-picked words: empty table, extremes, ties, reversed query, ignored code
   task automatic test_directed_cases();
      send_word(OP_QUERY, 32'd100, 32'd200, 4'd0);
      send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      send_word(OP_QUERY, 32'd500, 32'd20, 4'd0);
      send_word(OP_LOAD, 32'd0, 32'd0, 4'd0);
      send_word(OP_LOAD, 32'd1000, 32'd500, 4'd15);
      send_word(OP_LOAD, 32'd1200, 32'd500, 4'd3);
      send_word(OP_LOAD, 32'hFFFF_FF00, 32'hFFFF_FFFF, 4'd7);
      send_word(OP_QUERY, 32'd1100, 32'd1400, 4'd0);
      // equal overlap for two speakers
      send_word(OP_QUERY, 32'd1200, 32'd1500, 4'd0);
      send_word(OP_QUERY, 32'd5000, 32'd6000, 4'd0);
      send_word(OP_QUERY, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 4'd0);
      send_word(OP_QUERY, 32'd0, 32'hFFFF_FFFF, 4'd0);
      send_word(OP_QUERY, 32'd1500, 32'd1000, 4'd0);
      // equal midpoint distance, then same speaker with two starts
      send_word(OP_LOAD, 32'd2000, 32'd100, 4'd9);
      send_word(OP_LOAD, 32'd3000, 32'd100, 4'd4);
      send_word(OP_LOAD, 32'd2900, 32'd300, 4'd4);
      send_word(OP_QUERY, 32'd2550, 32'd2550, 4'd0);
      send_word(OP_QUERY, 32'd3050, 32'd3050, 4'd0);
      send_word(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
      send_word(OP_CLEAR, 32'd0, 32'd0, 4'd0);
      send_word(OP_QUERY, 32'd1100, 32'd1400, 4'd0);
      send_word(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
      send_word(OP_QUERY, 32'd0, 32'd0, 4'd0);
      send_word(OP_QUERY, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
   endtask

   // clear, load a batch of intervals, then query around them
   task automatic random_session();
      logic [TIME_W-1:0] base, reach, ts, te;
      int                n_load, n_query;
      bit                narrow, mixed;
      case ($urandom_range(3))
         0: base = '0;
         1: base = $urandom;
         2: base = 32'hFFFF_FFFF - $urandom_range(100000);
         default: base = $urandom_range(5000);
      endcase
      case ($urandom_range(3))
         0: reach = 32'd64;
         1: reach = 32'd4000;
         2: reach = 32'h0010_0000;
         default: reach = 32'hFFFF_FFFF;
      endcase
      narrow = ($urandom_range(1) == 1);
      mixed = ($urandom_range(3) == 0);
      if ($urandom_range(9) != 0 || tbl_count > 200)
         send_word(OP_CLEAR, $urandom, $urandom, LABEL_W'($urandom_range(15)));
      // an occasional large table, most stay small
      if ($urandom_range(29) == 0) begin
         n_load = $urandom_range(250, 60);
         n_query = $urandom_range(3, 1);
      end else begin
         n_load = $urandom_range(12);
         n_query = $urandom_range(6, 1);
      end
      if (n_load > MAX_ENTRIES - tbl_count) n_load = MAX_ENTRIES - tbl_count;
      while (n_load + n_query > 0) begin
         if ($urandom_range(19) == 0)
            send_word(OP_UNUSED, $urandom, $urandom, LABEL_W'($urandom_range(15)));
         if (n_query > 0 && (n_load == 0 || (mixed && $urandom_range(2) == 0))) begin
            ts = base + $urandom_range(reach);
            case ($urandom_range(9))
               0: te = ts - $urandom_range(reach);
               1: te = $urandom;
               default: te = ts + $urandom_range(reach);
            endcase
            send_word(OP_QUERY, ts, te, LABEL_W'($urandom_range(15)));
            n_query--;
         end else begin
            send_word(OP_LOAD, base + $urandom_range(reach), $urandom_range(reach),
                      narrow ? LABEL_W'($urandom_range(3)) : LABEL_W'($urandom_range(15)));
            n_load--;
         end
      end
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_chance);
      int target;
      send_idle_pct = idle_pct;
      stall_pct = stall_chance;
      target = n_words + PHASE_WORDS;
      while (n_words < target) random_session();
      wait_for_answers();
   endtask

   // fill the table, drop a few loads, then query the full table
   task automatic test_table_overflow();
      send_idle_pct = 29;
      stall_pct = 29;
      send_word(OP_CLEAR, 32'd0, 32'd0, 4'd0);
      for (int i = 0; i < MAX_ENTRIES + 3; i++)
         send_word(OP_LOAD, 32'd10000 + $urandom_range(5000), $urandom_range(2000),
                   LABEL_W'($urandom_range(15)));
      send_word(OP_QUERY, 32'd11000, 32'd14000, 4'd0);
      send_word(OP_QUERY, 32'd1, 32'd2, 4'd0);
      send_word(OP_QUERY, 32'd20000, 32'd100, 4'd0);
      send_word(OP_CLEAR, 32'd0, 32'd0, 4'd0);
      send_word(OP_QUERY, 32'd11000, 32'd14000, 4'd0);
      send_word(OP_LOAD, 32'd50, 32'd10, 4'd6);
      send_word(OP_QUERY, 32'd0, 32'd100, 4'd0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      wait_for_answers();
      test_random_traffic(0, 0);
      test_random_traffic(73, 0);
      test_random_traffic(0, 73);
      test_random_traffic(29, 29);
      test_table_overflow();

      // drain and let any late answer show up
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d request words across directed, four idling phases and a full table",
               n_words);
      $display("checked %0d answers: %0d by nearest midpoint, %0d on an empty table",
               n_results, n_nearest, n_unknown);
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/iolp_pkg.sv
rtl/iolp_ram.sv
rtl/interval_overlap_label_picker.sv
rtl/iolp_checker.sv
test/testbench.sv
